// ===== src/irpsd_pkg.sv =====
// Shared types and constants for the IR pulse and space duration capture block.
package irpsd_pkg;

    localparam int unsigned PRESCALE_SEL_W = 3;
    localparam int unsigned PRESCALE_CNT_W = 8;
    localparam int unsigned DURATION_W     = 16;
    localparam int unsigned FLUSH_W        = 17;
    localparam int unsigned BYTE_W         = 8;
    localparam int unsigned CFG_INDEX_W    = 2;
    localparam int unsigned CFG_DATA_W     = 17;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_PRESCALE_SELECT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SWAP_BYTE_ORDER = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FLUSH_PERIOD    = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [PRESCALE_SEL_W-1:0] PRESCALE_SELECT_RST = 3'b111;
    localparam logic                      SWAP_BYTE_ORDER_RST = 1'b0;
    localparam logic [FLUSH_W-1:0]        FLUSH_PERIOD_RST    = 17'h10000;

    // Duration word sent when the counter wraps.
    localparam logic [DURATION_W-1:0] DURATION_MAX = 16'hFFFF;
    localparam logic [BYTE_W-1:0]     BYTE_ALL_ONES = 8'hFF;

    typedef struct packed {
        logic [PRESCALE_SEL_W-1:0] prescale_select;
        logic                      swap_byte_order;
        logic [FLUSH_W-1:0]        flush_period;
    } t_cfg;

    typedef struct packed {
        logic valid;
        logic level;
    } t_step;

    typedef struct packed {
        logic [BYTE_W-1:0] first_byte;
        logic [BYTE_W-1:0] second_byte;
        logic              word_valid;
        logic              flush_mark;
    } t_result;

endpackage

// ===== src/ir_pulse_space_duration_capture.sv =====
// Top level of the IR pulse and space duration capture block.
//
// The block takes one sampled IR receiver level per beat on the input channel
// and can accept a new beat in every clock cycle while the result register
// moves on. Each beat is held in an input register and is then processed in a
// single pass into the result register when that register moves on. A result
// is thus offered once its beat has passed the input and result registers.
// The sustained rate is one beat per cycle, limited only by the result
// register, which moves on whenever it is empty or its beat is being taken.
// Capture stays idle until a falling edge. While running, a prescaler divides
// the beat rate by 2^(prescale_select+1), and each prescaler period advances a
// 16-bit duration counter. Every level change sends the measured duration as
// two bytes, high byte first unless swap_byte_order is set, and restarts the
// count. When the duration counter wraps, the terminator 0xFFFF is sent with a
// flush mark and capture returns to idle. An independent timer, cleared on each
// edge, raises a flush mark alone (word_valid low, bytes zero) each time
// flush_period beats pass without an edge; a period of zero behaves as one.
// Configuration registers are written through their own channel, which is
// always ready. They should only be written while the block is idle. Writes to
// an index beyond the register list are ignored.
module ir_pulse_space_duration_capture (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Sample channel
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic                                   i_ir_level,
    // Result channel
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic [irpsd_pkg::BYTE_W-1:0]           o_first_byte,
    output logic [irpsd_pkg::BYTE_W-1:0]           o_second_byte,
    output logic                                   o_word_valid,
    output logic                                   o_flush_mark,
    // Configuration channel
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [irpsd_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [irpsd_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import irpsd_pkg::*;

    t_cfg    r_cfg;
    t_step   step;
    t_result res;
    t_result r_out;
    logic    r_out_valid;
    logic    res_valid;
    logic    advance;
    logic    fire;

    // The result register moves on when it is empty or its beat is taken.
    assign advance = !r_out_valid || i_out_ready;
    assign fire    = step.valid && advance;

    // Configuration registers: always ready, unknown indexes are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prescale_select <= PRESCALE_SELECT_RST;
            r_cfg.swap_byte_order <= SWAP_BYTE_ORDER_RST;
            r_cfg.flush_period    <= FLUSH_PERIOD_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PRESCALE_SELECT: begin
                    r_cfg.prescale_select <= i_cfg_data[PRESCALE_SEL_W-1:0];
                end
                CFG_SWAP_BYTE_ORDER: begin
                    r_cfg.swap_byte_order <= i_cfg_data[0];
                end
                CFG_FLUSH_PERIOD: begin
                    r_cfg.flush_period <= i_cfg_data[FLUSH_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    irpsd_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_ir_level (i_ir_level),
        .i_advance  (advance),
        .o_step     (step)
    );

    irpsd_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_step      (step),
        .i_cfg       (r_cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Result register. Beats that produce no result simply leave it empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= fire && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_first_byte  = r_out.first_byte;
    assign o_second_byte = r_out.second_byte;
    assign o_word_valid  = r_out.word_valid;
    assign o_flush_mark  = r_out.flush_mark;

`ifndef ASSERT_OFF
    // A result always carries either a word or a flush mark.
    a_result_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_word_valid || o_flush_mark))
        else $error("result beat carries neither a word nor a flush mark");

    // A flush mark alongside a word only comes with the terminator.
    a_terminator_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_word_valid && o_flush_mark) |->
        (o_first_byte == BYTE_ALL_ONES && o_second_byte == BYTE_ALL_ONES))
        else $error("flush mark with a word that is not the terminator");

    // A flush mark alone has zero bytes.
    a_flush_only_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_word_valid) |->
        (o_first_byte == '0 && o_second_byte == '0))
        else $error("flush-only beat with non-zero bytes");

    // When the result side takes beats, the sample side is never stalled.
    a_no_stall_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> o_in_ready)
        else $error("sample channel stalled while results are being taken");

    // A waiting result is not dropped.
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("pending result dropped before being taken");
`endif

endmodule

// ===== src/irpsd_in_stage.sv =====
// Input register holding one sampled receiver level beat until the engine takes it.
module irpsd_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic           i_ir_level,
    input  logic           i_advance,
    output irpsd_pkg::t_step o_step
);
    import irpsd_pkg::*;

    logic r_valid;
    logic r_level;

    assign o_in_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_level <= i_ir_level;
        end
    end

    assign o_step.valid = r_valid;
    assign o_step.level = r_level;

endmodule

// ===== src/irpsd_engine.sv =====
// Capture state and per-tick step logic: edge detection, prescaler, duration and flush timers.
module irpsd_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  irpsd_pkg::t_step   i_step,
    input  irpsd_pkg::t_cfg    i_cfg,
    output logic               o_res_valid,
    output irpsd_pkg::t_result o_res
);
    import irpsd_pkg::*;

    logic                      r_running;
    logic                      r_prev_level;
    logic [PRESCALE_CNT_W-1:0] r_prescale;
    logic [DURATION_W-1:0]     r_duration;
    logic [FLUSH_W-1:0]        r_flush;

    logic                      n_running;
    logic [PRESCALE_CNT_W-1:0] n_prescale;
    logic [DURATION_W-1:0]     n_duration;
    logic [FLUSH_W-1:0]        n_flush;

    logic                      changed;
    logic [PRESCALE_CNT_W:0]   prescale_inc;
    logic [PRESCALE_CNT_W:0]   prescale_limit;
    logic [FLUSH_W:0]          flush_inc;
    logic [FLUSH_W-1:0]        period;
    logic                      overflow;
    logic                      flush_hit;
    logic [DURATION_W-1:0]     word;

    assign changed        = i_step.level != r_prev_level;
    assign prescale_inc   = {1'b0, r_prescale} + 1'b1;
    assign prescale_limit = (PRESCALE_CNT_W+1)'(2) << i_cfg.prescale_select;
    assign flush_inc      = {1'b0, r_flush} + 1'b1;
    assign period         = (i_cfg.flush_period == '0) ? FLUSH_W'(1) : i_cfg.flush_period;

    always_comb begin
        n_running   = r_running;
        n_prescale  = r_prescale;
        n_duration  = r_duration;
        n_flush     = r_flush;
        overflow    = 1'b0;
        flush_hit   = 1'b0;
        word        = '0;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (!r_running) begin
            if (changed && !i_step.level) begin
                n_running  = 1'b1;
                n_prescale = '0;
                n_duration = '0;
                n_flush    = '0;
            end
        end else if (changed) begin
            // An edge closes the current pulse or space.
            word              = r_duration;
            o_res_valid       = 1'b1;
            o_res.word_valid  = 1'b1;
            n_prescale        = '0;
            n_duration        = '0;
            n_flush           = '0;
        end else begin
            if (prescale_inc >= prescale_limit) begin
                n_prescale = '0;
                if (r_duration == DURATION_MAX) begin
                    overflow   = 1'b1;
                    n_duration = '0;
                end else begin
                    n_duration = r_duration + 1'b1;
                end
            end else begin
                n_prescale = prescale_inc[PRESCALE_CNT_W-1:0];
            end

            if (flush_inc >= {1'b0, period}) begin
                flush_hit = 1'b1;
                n_flush   = '0;
            end else begin
                n_flush = flush_inc[FLUSH_W-1:0];
            end

            if (overflow) begin
                word             = DURATION_MAX;
                o_res_valid      = 1'b1;
                o_res.word_valid = 1'b1;
                o_res.flush_mark = 1'b1;
                n_running        = 1'b0;
                n_prescale       = '0;
                n_flush          = '0;
            end else if (flush_hit) begin
                o_res_valid      = 1'b1;
                o_res.flush_mark = 1'b1;
            end
        end

        if (i_cfg.swap_byte_order) begin
            o_res.first_byte  = word[BYTE_W-1:0];
            o_res.second_byte = word[DURATION_W-1:BYTE_W];
        end else begin
            o_res.first_byte  = word[DURATION_W-1:BYTE_W];
            o_res.second_byte = word[BYTE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running    <= 1'b0;
            r_prev_level <= 1'b1;
            r_prescale   <= '0;
            r_duration   <= '0;
            r_flush      <= '0;
        end else if (i_fire) begin
            r_running    <= n_running;
            r_prev_level <= i_step.level;
            r_prescale   <= n_prescale;
            r_duration   <= n_duration;
            r_flush      <= n_flush;
        end
    end

endmodule
